### rtl/tcce_pkg.sv
// Shared types and constants of the text console cursor engine.
// Holds the request and response payload structs, command and control codes.
// Has no dependencies; every other file of the block uses it.
package tcce_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 6;
  localparam int LIN_W   = 14;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int CFG_DW  = 32;
  localparam int PADDR_W = 2;

  // Register map.
  localparam logic [PADDR_W-1:0] REG_TEXT_ATTR = 2'd0;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUT_CHAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_CELL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE_CURSOR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCROLL      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_CELL   = 3'd5;

  // Control characters handled by put_char.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0A;

  // Tab stops every eight columns; the column sum carries one extra bit.
  localparam logic [COL_W:0] TAB_STEP = 9'd8;
  localparam logic [COL_W:0] TAB_MASK = ~9'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  column;
    logic [7:0]        row;
    logic [ATTR_W-1:0] cell_attribute;
  } in_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attribute;
  } out_rsp_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                 input logic [ATTR_W-1:0] attr);
    make_cell = {attr, ch};
  endfunction

endpackage

### rtl/tcce_screen_ram.sv
// Screen cell memory of the text console cursor engine.
// One write port and one read port with registered read data.
// Depends on tcce_pkg for the cell width.
module tcce_screen_ram #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]     waddr,
  input  logic [tcce_pkg::CELL_W-1:0]         wdata,
  input  logic                                re,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]     raddr,
  output logic [tcce_pkg::CELL_W-1:0]         rdata
);

  localparam int DEPTH = COLUMNS * ROWS;

  logic [tcce_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tcce_addr_map.sv
// Maps a screen position to a linear cell address.
// The row is rotated by a row offset modulo ROWS before row * COLUMNS + column.
// Depends on tcce_pkg for the coordinate widths.
module tcce_addr_map #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic [tcce_pkg::COL_W-1:0]      col,
  input  logic [tcce_pkg::ROW_W-1:0]      row,
  input  logic [tcce_pkg::ROW_W-1:0]      offset,
  output logic [$clog2(COLUMNS*ROWS)-1:0] addr
);

  localparam int AW    = $clog2(COLUMNS * ROWS);
  localparam int ROW_W = tcce_pkg::ROW_W;
  localparam int LIN_W = tcce_pkg::LIN_W;

  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] prow;
  logic [LIN_W-1:0] lin;

  always_comb begin
    row_sum = {1'b0, row} + {1'b0, offset};
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      prow = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
    end else begin
      prow = row_sum[ROW_W-1:0];
    end
    lin  = LIN_W'(prow) * LIN_W'(COLUMNS) + LIN_W'(col);
    addr = lin[AW-1:0];
  end

endmodule

### rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: control sequencer, cursor,
// configuration register and output register. Depends on tcce_pkg,
// tcce_addr_map and tcce_screen_ram.
//
//   Channel   Ports                                        Moves
//   input     in_valid, in_stall, in_req                   one command request
//   output    out_valid, out_stall, out_rsp                one cursor/read result
//   config    psel, penable, pwrite, paddr, pwdata,        text_attribute register
//             prdata, pready
//
// A request passes through an execute cycle that reads or writes the screen
// memory and updates the cursor, and a finish cycle that loads the output
// register. A scroll, or a put_char that scrolls, adds a sweep that blanks
// the new bottom row; a clear sweeps every cell. Both sweeps are paced by the
// single write port of the screen memory, one cell per cycle.
// After reset the block blanks the whole screen and holds in_stall high
// meanwhile; configuration writes are taken throughout. The next request is
// taken in the finish cycle, so a stalled output delays acceptance only while
// its register is still full.
//
// Scrolling does not move cells: a top-row offset rotates the logical rows
// onto the physical rows of the memory, and only the freed row is rewritten.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command requests.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tcce_pkg::in_req_t                 in_req,
  // Results.
  output logic                              out_valid,
  input  logic                              out_stall,
  output tcce_pkg::out_rsp_t                out_rsp,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]      paddr,
  input  logic [tcce_pkg::CFG_DW-1:0]       pwdata,
  output logic [tcce_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int AW     = $clog2(COLUMNS * ROWS);
  localparam int COL_W  = tcce_pkg::COL_W;
  localparam int ROW_W  = tcce_pkg::ROW_W;
  localparam int CELL_W = tcce_pkg::CELL_W;
  localparam int ATTR_W = tcce_pkg::ATTR_W;
  localparam int CHAR_W = tcce_pkg::CHAR_W;
  localparam int LIN_W  = tcce_pkg::LIN_W;

  localparam logic [COL_W:0]   COLS_X    = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_X    = (ROW_W+1)'(ROWS);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [AW-1:0]    LAST_CELL = AW'(COLUMNS * ROWS - 1);
  localparam logic [AW-1:0]    ROW_SPAN  = AW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  tcce_pkg::in_req_t      req_r, req_nxt;
  logic [COL_W-1:0]       cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]       cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]       top_r, top_nxt;
  logic [ATTR_W-1:0]      text_attr_r, text_attr_nxt;
  logic [AW-1:0]          sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]          sweep_last_r, sweep_last_nxt;
  logic [CELL_W-1:0]      fill_cell_r, fill_cell_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic                   out_vld_r, out_vld_nxt;
  tcce_pkg::out_rsp_t     out_rsp_r, out_rsp_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   cfg_wr;

  // put_char cursor arithmetic.
  logic [COL_W:0]         pc_col_a, pc_col_b;
  logic [ROW_W:0]         pc_row_a, pc_row_b, pc_row_c;
  logic                   pc_we;
  logic                   pc_scroll;
  logic [COL_W-1:0]       pc_wcol;
  logic [ROW_W-1:0]       pc_wrow;
  logic [CHAR_W-1:0]      pc_wchar;

  // Execute-cycle decode.
  logic                   in_range;
  logic [ROW_W-1:0]       top_inc;
  logic                   ex_we;
  logic                   ex_re;
  logic                   sweep_go;
  logic                   sweep_full;
  logic [COL_W-1:0]       ex_col;
  logic [ROW_W-1:0]       ex_row;
  logic [CELL_W-1:0]      ex_data;

  // Memory and address map connections.
  logic [AW-1:0]          ex_addr;
  logic [AW-1:0]          base_addr;
  logic [AW-1:0]          cur_lin;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [CELL_W-1:0]      ram_wdata;
  logic [CELL_W-1:0]      ram_rdata;

  // ---------------------------------------------------------------------------
  // Handshakes. A request is taken when idle, or in the finish cycle when the
  // result can go into the output register at the same edge.
  // ---------------------------------------------------------------------------
  assign out_free  = !out_vld_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == tcce_pkg::REG_TEXT_ATTR);
  assign prdata = (paddr == tcce_pkg::REG_TEXT_ATTR) ?
                  tcce_pkg::CFG_DW'(text_attr_r) : '0;

  // ---------------------------------------------------------------------------
  // Address maps: the cell addressed by the request, the physical base of the
  // current top row, and the unrotated linear cursor position.
  // ---------------------------------------------------------------------------
  tcce_addr_map #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_ex_map (
    .col    (ex_col),
    .row    (ex_row),
    .offset (top_r),
    .addr   (ex_addr)
  );

  tcce_addr_map #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_base_map (
    .col    ('0),
    .row    ('0),
    .offset (top_r),
    .addr   (base_addr)
  );

  tcce_addr_map #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_lin_map (
    .col    (cur_col_r),
    .row    (cur_row_r),
    .offset ('0),
    .addr   (cur_lin)
  );

  // The sweep owns the write port during reset blanking and fills; otherwise
  // the execute cycle writes a single cell.
  always_comb begin
    if ((state_r == ST_INIT) || (state_r == ST_SWEEP)) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = fill_cell_r;
    end else begin
      ram_we    = (state_r == ST_EXEC) && ex_we;
      ram_waddr = ex_addr;
      ram_wdata = ex_data;
    end
  end

  tcce_screen_ram #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    ((state_r == ST_EXEC) && ex_re),
    .raddr (ex_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // put_char: control codes move the cursor, backspace blanks the cell it
  // lands on, every other code is written at the cursor. Column overflow
  // wraps to the next row; running off the bottom row scrolls.
  // ---------------------------------------------------------------------------
  always_comb begin
    pc_col_a = {1'b0, cur_col_r};
    pc_row_a = {1'b0, cur_row_r};
    pc_we    = 1'b0;
    pc_wcol  = cur_col_r;
    pc_wrow  = cur_row_r;
    pc_wchar = req_r.char_code;
    case (req_r.char_code)
      tcce_pkg::CH_NEWLINE: begin
        pc_col_a = '0;
        pc_row_a = {1'b0, cur_row_r} + 1'b1;
      end
      tcce_pkg::CH_RETURN: begin
        pc_col_a = '0;
      end
      tcce_pkg::CH_BACKSPACE: begin
        if (cur_col_r != '0) begin
          pc_col_a = {1'b0, cur_col_r} - 1'b1;
        end else if (cur_row_r != '0) begin
          pc_col_a = {1'b0, LAST_COL};
          pc_row_a = {1'b0, cur_row_r} - 1'b1;
        end
        pc_we    = 1'b1;
        pc_wcol  = pc_col_a[COL_W-1:0];
        pc_wrow  = pc_row_a[ROW_W-1:0];
        pc_wchar = tcce_pkg::BLANK_CHAR;
      end
      tcce_pkg::CH_TAB: begin
        pc_col_a = ({1'b0, cur_col_r} + tcce_pkg::TAB_STEP) & tcce_pkg::TAB_MASK;
      end
      default: begin
        pc_we    = 1'b1;
        pc_col_a = {1'b0, cur_col_r} + 1'b1;
      end
    endcase

    if (pc_col_a >= COLS_X) begin
      pc_col_b = '0;
      pc_row_b = pc_row_a + 1'b1;
    end else begin
      pc_col_b = pc_col_a;
      pc_row_b = pc_row_a;
    end

    pc_scroll = (pc_row_b >= ROWS_X);
    pc_row_c  = pc_scroll ? (pc_row_b - 1'b1) : pc_row_b;
  end

  // ---------------------------------------------------------------------------
  // Execute-cycle decode of the held request.
  // ---------------------------------------------------------------------------
  assign in_range = ({1'b0, req_r.column} < COLS_X) && (req_r.row < 8'(ROWS));
  assign top_inc  = (top_r == LAST_ROW) ? '0 : (top_r + 1'b1);

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    top_nxt     = top_r;
    ex_we       = 1'b0;
    ex_re       = 1'b0;
    sweep_go    = 1'b0;
    sweep_full  = 1'b0;
    ex_col      = req_r.column;
    ex_row      = req_r.row[ROW_W-1:0];
    ex_data     = tcce_pkg::make_cell(req_r.char_code, req_r.cell_attribute);
    case (req_r.command)
      tcce_pkg::CMD_PUT_CHAR: begin
        cur_col_nxt = pc_col_b[COL_W-1:0];
        cur_row_nxt = pc_row_c[ROW_W-1:0];
        ex_we       = pc_we;
        ex_col      = pc_wcol;
        ex_row      = pc_wrow;
        ex_data     = tcce_pkg::make_cell(pc_wchar, text_attr_r);
        if (pc_scroll) begin
          top_nxt  = top_inc;
          sweep_go = 1'b1;
        end
      end
      tcce_pkg::CMD_SET_CELL: begin
        ex_we = in_range;
      end
      tcce_pkg::CMD_MOVE_CURSOR: begin
        cur_col_nxt = ({1'b0, req_r.column} < COLS_X) ? req_r.column : LAST_COL;
        cur_row_nxt = (req_r.row < 8'(ROWS)) ? req_r.row[ROW_W-1:0] : LAST_ROW;
      end
      tcce_pkg::CMD_CLEAR: begin
        cur_col_nxt = '0;
        cur_row_nxt = '0;
        top_nxt     = '0;
        sweep_go    = 1'b1;
        sweep_full  = 1'b1;
      end
      tcce_pkg::CMD_SCROLL: begin
        if (cur_row_r != '0) begin
          cur_row_nxt = cur_row_r - 1'b1;
        end
        top_nxt  = top_inc;
        sweep_go = 1'b1;
      end
      tcce_pkg::CMD_READ_CELL: begin
        ex_re = in_range;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    fill_cell_nxt  = fill_cell_r;
    rd_ok_nxt      = rd_ok_r;
    out_rsp_nxt    = out_rsp_r;
    out_vld_nxt    = out_vld_r && out_stall;
    text_attr_nxt  = cfg_wr ? pwdata[ATTR_W-1:0] : text_attr_r;

    if (in_acc) begin
      req_nxt = in_req;
    end

    case (state_r)
      ST_INIT: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == sweep_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_ok_nxt = ex_re;
        if (sweep_go) begin
          // The freed row is the old top row; a clear rewrites every cell.
          state_nxt      = ST_SWEEP;
          sweep_addr_nxt = sweep_full ? '0 : base_addr;
          sweep_last_nxt = sweep_full ? LAST_CELL : (base_addr + ROW_SPAN);
          fill_cell_nxt  = tcce_pkg::make_cell(tcce_pkg::BLANK_CHAR, text_attr_r);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == sweep_last_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_nxt                = 1'b1;
          out_rsp_nxt.cursor_column  = cur_col_r;
          out_rsp_nxt.cursor_row     = cur_row_r;
          out_rsp_nxt.cursor_linear  = LIN_W'(cur_lin);
          out_rsp_nxt.read_char      = rd_ok_r ? ram_rdata[CHAR_W-1:0] : '0;
          out_rsp_nxt.read_attribute = rd_ok_r ? ram_rdata[CELL_W-1:CHAR_W] : '0;
          state_nxt                  = in_acc ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers. The reset starts the blanking sweep over the whole screen with
  // the reset attribute. The held request and the result payload need no
  // reset; they are only looked at once their state says they are loaded.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      top_r        <= '0;
      text_attr_r  <= tcce_pkg::RESET_ATTR;
      sweep_addr_r <= '0;
      sweep_last_r <= LAST_CELL;
      fill_cell_r  <= tcce_pkg::make_cell(tcce_pkg::BLANK_CHAR, tcce_pkg::RESET_ATTR);
      rd_ok_r      <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      text_attr_r  <= text_attr_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_last_r <= sweep_last_nxt;
      fill_cell_r  <= fill_cell_nxt;
      rd_ok_r      <= rd_ok_nxt;
      out_vld_r    <= out_vld_nxt;
      req_r        <= req_nxt;
      out_rsp_r    <= out_rsp_nxt;
      if (state_r == ST_EXEC) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
        top_r     <= top_nxt;
      end
    end
  end

endmodule
